>>> hdl/nested_exception_time_profiler_macros.svh
// Assertion macros for the exception time profiler
`ifndef NESTED_EXCEPTION_TIME_PROFILER_MACROS_SVH
`define NESTED_EXCEPTION_TIME_PROFILER_MACROS_SVH
`ifndef SYNTHESIS
`define NETP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define NETP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define NETP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define NETP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/netp_pkg.sv
`timescale 1ns / 1ps
package netp_pkg;
    localparam int unsigned NumExceptionsDef = 512;
    localparam int unsigned TimeBitsDef = 48;
    localparam int unsigned StatBits = 48;
    localparam int unsigned DepthBits = 10;
    localparam int unsigned ExcBits = 10;
    localparam logic [9:0] NoneExc = 10'd512;
    localparam logic [9:0] DepthMax = 10'd1023;
    localparam logic [31:0] VisitMax = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ACT_TICK = 3'd0, ACT_ENTER = 3'd1, ACT_EXIT = 3'd2,
        ACT_RESUME = 3'd3, ACT_READ = 3'd4, ACT_OVF = 3'd5
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_RD_CUR, S_ENTER, S_ENTER_NEW, S_POP_RD, S_POP_WR,
        S_PREV_RD, S_PREV_WR, S_READ_RD, S_READ_WR, S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       load;      // capture request
        logic       tick;
        logic       rd_exc;    // address memories with request exception
        logic       rd_cur;    // address memories with current exception
        logic       wr_enter_cur;
        logic       wr_enter_new;
        logic       wr_pop;
        logic       wr_prev;
        logic       wr_clear;
        logic       dec_depth;
        logic       zero_depth;
        logic       set_read;
        logic       out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_action    action;
        logic       exc_valid;
        logic       live;
        logic       cur_none;
        logic       cur_is_exc;
        logic       depth_zero;
        logic       prev_valid;
        logic       cur_valid;
    } t_stat;
endpackage

>>> hdl/nested_exception_time_profiler.sv
`timescale 1ns / 1ps
// Nested exception time profiler. Each request is taken in the idle state and
// its result is registered. A tick, depth reset, unused action or exit with
// nothing current goes straight to output; enter reads the new and current
// records, then (unless ignored) charges the running handler and opens the new
// record; read fetches and clears a record; exit pops the current record and
// updates the outer one, and resume does so per unwound level (a level with no
// handler current only drops depth). The record memories share one read port;
// a stalled result holds the output state. After reset the block clears its
// record memories, one entry a cycle, and holds o_in_stall high meanwhile.
module nested_exception_time_profiler
    import netp_pkg::*;
#(
    parameter int unsigned NUM_EXCEPTIONS = NumExceptionsDef,
    parameter int unsigned TIME_BITS = TimeBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [8:0]  i_exception_number,
    input  logic [31:0] i_time_increment,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_record_valid,
    output logic [31:0] o_visits,
    output logic [9:0]  o_peak_depth,
    output logic [47:0] o_total_time,
    output logic [47:0] o_min_time,
    output logic [47:0] o_max_time,
    output logic [47:0] o_max_wall_time,
    output logic [9:0]  o_current_exception,
    output logic [9:0]  o_nesting_depth
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_clr_busy;

    netp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall), .i_clr_busy(w_clr_busy),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    netp_dp #(.NumExceptions(NUM_EXCEPTIONS), .TimeBits(TIME_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_action(i_action),
        .i_exception_number(i_exception_number),
        .i_time_increment(i_time_increment), .i_cmd(w_cmd), .o_stat(w_stat),
        .o_clr_busy(w_clr_busy), .o_record_valid(o_record_valid),
        .o_visits(o_visits), .o_peak_depth(o_peak_depth),
        .o_total_time(o_total_time), .o_min_time(o_min_time),
        .o_max_time(o_max_time), .o_max_wall_time(o_max_wall_time),
        .o_current_exception(o_current_exception),
        .o_nesting_depth(o_nesting_depth)
    );
endmodule

>>> hdl/netp_ram.sv
`timescale 1ns / 1ps
module netp_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/netp_ctrl.sv
`timescale 1ns / 1ps
module netp_ctrl
    import netp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  logic  i_clr_busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = i_clr_busy;
                if (i_in_valid && !i_clr_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                unique case (i_stat.action)
                    ACT_TICK: begin
                        o_cmd.tick = 1'b1;
                        n_state    = S_OUT;
                    end
                    ACT_ENTER: begin
                        o_cmd.rd_exc = 1'b1;
                        n_state      = S_RD_CUR;
                    end
                    ACT_EXIT: begin
                        o_cmd.rd_cur = 1'b1;
                        n_state = i_stat.cur_none ? S_OUT : S_POP_RD;
                    end
                    ACT_RESUME: begin
                        o_cmd.rd_cur = 1'b1;
                        if (i_stat.cur_is_exc || i_stat.depth_zero) begin
                            n_state = S_OUT;
                        end else if (i_stat.cur_none) begin
                            o_cmd.dec_depth = 1'b1;
                            n_state = S_DECIDE;
                        end else begin
                            n_state = S_POP_RD;
                        end
                    end
                    ACT_READ: begin
                        o_cmd.rd_exc = 1'b1;
                        n_state = i_stat.exc_valid ? S_READ_RD : S_OUT;
                    end
                    ACT_OVF: begin
                        o_cmd.zero_depth = 1'b1;
                        n_state = S_OUT;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_RD_CUR: begin
                // stamp of the new exception is now read; fetch the current one
                o_cmd.rd_cur = 1'b1;
                n_state = (!i_stat.exc_valid || i_stat.live) ? S_OUT : S_ENTER;
            end
            S_ENTER: begin
                // charge the running handler first, then open the new record
                o_cmd.wr_enter_cur = i_stat.cur_valid;
                n_state = S_ENTER_NEW;
            end
            S_ENTER_NEW: begin
                o_cmd.wr_enter_new = 1'b1;
                n_state = S_OUT;
            end
            S_POP_RD: begin
                o_cmd.rd_cur = 1'b1;
                n_state = S_POP_WR;
            end
            S_POP_WR: begin
                o_cmd.wr_pop = 1'b1;
                n_state = i_stat.prev_valid ? S_PREV_RD : S_PREV_WR;
            end
            S_PREV_RD: begin
                // current now names the outer handler
                o_cmd.rd_cur = 1'b1;
                n_state = S_PREV_WR;
            end
            S_PREV_WR: begin
                o_cmd.wr_prev = 1'b1;
                n_state = (i_stat.action == ACT_RESUME) ? S_DECIDE : S_OUT;
            end
            S_READ_RD: begin
                o_cmd.rd_exc = 1'b1;
                n_state = S_READ_WR;
            end
            S_READ_WR: begin
                o_cmd.wr_clear = 1'b1;
                o_cmd.set_read = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

    `include "nested_exception_time_profiler_macros.svh"
    `NETP_ASSERT_IMPL(a_load_idle, i_clk, i_rst_n, o_cmd.load, r_state == S_IDLE)
    `NETP_ASSERT_NEXT(a_out_after_load, i_clk, i_rst_n, o_cmd.out_load, o_out_valid)
    `NETP_ASSERT_IMPL(a_no_clear_accept, i_clk, i_rst_n, i_clr_busy, o_in_stall)
endmodule

>>> hdl/netp_dp.sv
`timescale 1ns / 1ps
module netp_dp
    import netp_pkg::*;
#(
    parameter int unsigned NumExceptions = NumExceptionsDef,
    parameter int unsigned TimeBits = TimeBitsDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [2:0]           i_action,
    input  logic [8:0]           i_exception_number,
    input  logic [31:0]          i_time_increment,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic                 o_clr_busy,
    output logic                 o_record_valid,
    output logic [31:0]          o_visits,
    output logic [DepthBits-1:0] o_peak_depth,
    output logic [StatBits-1:0]  o_total_time,
    output logic [StatBits-1:0]  o_min_time,
    output logic [StatBits-1:0]  o_max_time,
    output logic [StatBits-1:0]  o_max_wall_time,
    output logic [ExcBits-1:0]   o_current_exception,
    output logic [DepthBits-1:0] o_nesting_depth
);
    localparam int unsigned AW = $clog2(NumExceptions);
    // timing word: stamp, own, stolen, link
    localparam int unsigned TW = 3 * TimeBits + ExcBits;
    // statistics word: visits, deepest, sum, least, most, wall
    localparam int unsigned SW = 32 + DepthBits + 4 * StatBits;
    localparam logic [StatBits-1:0] F48 = '1;

    logic [2:0]          r_act;
    logic [8:0]          r_exc;
    logic [31:0]         r_inc;
    logic [TimeBits-1:0] r_now;
    logic [ExcBits-1:0]  r_cur;
    logic [DepthBits-1:0] r_depth;
    logic [AW:0]         r_clr;
    logic                r_rd_valid;
    // read record held until the result register is free
    logic [31:0]         r_rd_visits;
    logic [DepthBits-1:0] r_rd_deep;
    logic [StatBits-1:0] r_rd_sum, r_rd_least, r_rd_most, r_rd_wall;
    logic [31:0]         r_o_visits;
    logic [DepthBits-1:0] r_o_deep;
    logic [StatBits-1:0] r_o_sum, r_o_least, r_o_most, r_o_wall;
    logic                r_o_rv;
    logic [ExcBits-1:0]  r_o_cur;
    logic [DepthBits-1:0] r_o_depth;
    // popped record held across the link update
    logic [TimeBits-1:0] r_used, r_steal;

    logic [AW-1:0] w_raddr, w_twaddr, w_swaddr;
    logic [TW-1:0] w_trd, w_twd;
    logic [SW-1:0] w_srd, w_swd;
    logic          w_twe, w_swe;
    logic [TimeBits-1:0] t_stamp, t_own, t_stolen;
    logic [ExcBits-1:0]  t_link;
    logic [31:0]         s_visits;
    logic [DepthBits-1:0] s_deep;
    logic [StatBits-1:0] s_sum, s_least, s_most, s_wall;
    logic [TimeBits-1:0] w_used, w_own;
    logic [StatBits-1:0] w_own48, w_steal48, w_sum_new, w_wall_new;
    logic [StatBits:0]   w_sum_ext, w_wall_ext;
    logic                w_exc_valid, w_cur_valid, w_prev_valid;

    assign {t_stamp, t_own, t_stolen, t_link} = w_trd;
    assign {s_visits, s_deep, s_sum, s_least, s_most, s_wall} = w_srd;

    assign w_exc_valid  = {1'b0, r_exc} < ExcBits'(NumExceptions);
    assign w_cur_valid  = r_cur < ExcBits'(NumExceptions);
    assign w_prev_valid = t_link < ExcBits'(NumExceptions);

    assign w_used = r_now - t_stamp;
    assign w_own  = t_own + w_used;
    assign w_own48   = StatBits'(w_own);
    assign w_steal48 = StatBits'(t_stolen);
    assign w_sum_ext  = {1'b0, s_sum} + {1'b0, w_own48};
    assign w_wall_ext = {1'b0, w_own48} + {1'b0, w_steal48};
    assign w_sum_new  = w_sum_ext[StatBits] ? F48 : w_sum_ext[StatBits-1:0];
    assign w_wall_new = w_wall_ext[StatBits] ? F48 : w_wall_ext[StatBits-1:0];

    // read address follows the controller's choice
    always_comb begin
        if (o_clr_busy) begin
            w_raddr = r_clr[AW-1:0];
        end else if (i_cmd.rd_cur) begin
            w_raddr = r_cur[AW-1:0];
        end else begin
            w_raddr = r_exc[AW-1:0];
        end
    end

    always_comb begin
        w_twe    = 1'b0;
        w_swe    = 1'b0;
        w_twaddr = r_exc[AW-1:0];
        w_swaddr = r_exc[AW-1:0];
        w_twd    = w_trd;
        w_swd    = w_srd;
        if (o_clr_busy) begin
            w_twe    = 1'b1;
            w_swe    = 1'b1;
            w_twaddr = r_clr[AW-1:0];
            w_swaddr = r_clr[AW-1:0];
            w_twd    = {{(3 * TimeBits){1'b0}}, NoneExc};
            w_swd    = '0;
        end else if (i_cmd.wr_enter_cur) begin
            w_twe    = 1'b1;
            w_twaddr = r_cur[AW-1:0];
            w_twd    = {t_stamp, w_own, t_stolen, t_link};
        end else if (i_cmd.wr_enter_new) begin
            w_twe = 1'b1;
            w_twd = {r_now, {(2 * TimeBits){1'b0}}, r_cur};
        end else if (i_cmd.wr_pop) begin
            w_twe    = 1'b1;
            w_twaddr = r_cur[AW-1:0];
            w_twd    = {{TimeBits{1'b0}}, w_own, t_stolen, t_link};
            w_swe    = 1'b1;
            w_swaddr = r_cur[AW-1:0];
            w_swd    = {(s_visits == VisitMax) ? s_visits : s_visits + 32'd1,
                        (r_depth > s_deep) ? r_depth : s_deep,
                        w_sum_new,
                        (s_least == '0 || w_own48 < s_least) ? w_own48 : s_least,
                        (w_own48 > s_most) ? w_own48 : s_most,
                        (w_wall_new > s_wall) ? w_wall_new : s_wall};
        end else if (i_cmd.wr_prev && w_cur_valid) begin
            w_twe    = 1'b1;
            w_twaddr = r_cur[AW-1:0];
            w_twd    = {r_now, t_own, t_stolen + r_used + r_steal, t_link};
        end else if (i_cmd.wr_clear) begin
            w_swe = 1'b1;
            w_swd = '0;
        end
    end

    netp_ram #(.Width(TW), .Depth(NumExceptions)) u_tmem (
        .i_clk(i_clk), .i_we(w_twe), .i_waddr(w_twaddr), .i_wdata(w_twd),
        .i_raddr(w_raddr), .o_rdata(w_trd)
    );
    netp_ram #(.Width(SW), .Depth(NumExceptions)) u_smem (
        .i_clk(i_clk), .i_we(w_swe), .i_waddr(w_swaddr), .i_wdata(w_swd),
        .i_raddr(w_raddr), .o_rdata(w_srd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now      <= '0;
            r_cur      <= NoneExc;
            r_depth    <= '0;
            r_clr      <= '0;
            r_rd_valid <= 1'b0;
            r_o_rv     <= 1'b0;
            r_o_cur    <= NoneExc;
            r_o_depth  <= '0;
        end else begin
            if (o_clr_busy) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.load) begin
                r_act      <= i_action;
                r_exc      <= i_exception_number;
                r_inc      <= i_time_increment;
                r_rd_valid <= 1'b0;
            end
            if (i_cmd.tick) begin
                r_now <= r_now + TimeBits'(r_inc);
            end
            if (i_cmd.wr_enter_new) begin
                r_cur   <= {1'b0, r_exc};
                r_depth <= (r_depth == DepthMax) ? r_depth : r_depth + 1'b1;
            end
            if (i_cmd.wr_pop) begin
                r_used  <= w_used;
                r_steal <= t_stolen;
                r_cur   <= w_prev_valid ? t_link : NoneExc;
                r_depth <= (r_depth == '0) ? r_depth : r_depth - 1'b1;
            end
            if (i_cmd.dec_depth) begin
                r_depth <= r_depth - 1'b1;
            end
            if (i_cmd.zero_depth) begin
                r_depth <= '0;
            end
            if (i_cmd.set_read) begin
                r_rd_valid  <= 1'b1;
                r_rd_visits <= s_visits;
                r_rd_deep   <= s_deep;
                r_rd_sum    <= s_sum;
                r_rd_least  <= s_least;
                r_rd_most   <= s_most;
                r_rd_wall   <= s_wall;
            end
            if (i_cmd.out_load) begin
                r_o_rv     <= r_rd_valid;
                r_o_visits <= r_rd_visits;
                r_o_deep   <= r_rd_deep;
                r_o_sum    <= r_rd_sum;
                r_o_least  <= r_rd_least;
                r_o_most   <= r_rd_most;
                r_o_wall   <= r_rd_wall;
                r_o_cur    <= r_cur;
                r_o_depth  <= r_depth;
            end
        end
    end

    assign o_clr_busy = !r_clr[AW];

    assign o_stat.action     = t_action'(r_act);
    assign o_stat.exc_valid  = w_exc_valid;
    assign o_stat.live       = t_stamp != '0;
    assign o_stat.cur_none   = r_cur == NoneExc;
    assign o_stat.cur_is_exc = r_cur == {1'b0, r_exc};
    assign o_stat.depth_zero = r_depth == '0;
    assign o_stat.prev_valid = w_prev_valid;
    assign o_stat.cur_valid  = w_cur_valid;

    assign o_record_valid      = r_o_rv;
    assign o_visits            = r_o_rv ? r_o_visits : '0;
    assign o_peak_depth        = r_o_rv ? r_o_deep : '0;
    assign o_total_time        = r_o_rv ? r_o_sum : '0;
    assign o_min_time          = r_o_rv ? r_o_least : '0;
    assign o_max_time          = r_o_rv ? r_o_most : '0;
    assign o_max_wall_time     = r_o_rv ? r_o_wall : '0;
    assign o_current_exception = r_o_cur;
    assign o_nesting_depth     = r_o_depth;
endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
    import netp_pkg::*;

    typedef struct packed {
        logic        rec_valid;
        logic [31:0] visits;
        logic [9:0]  peak_depth;
        logic [47:0] total;
        logic [47:0] min_t;
        logic [47:0] max_t;
        logic [47:0] max_wall;
        logic [9:0]  cur_exc;
        logic [9:0]  depth;
    } profile_t;

    localparam int unsigned NREC = 512;
    localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;
    localparam int unsigned CYCLE_LIMIT = 600000;

    class profile_scoreboard;
        logic [47:0] now;
        logic [9:0]  cur;
        logic [9:0]  depth;
        logic [47:0] stamp [NREC];
        logic [47:0] own [NREC];
        logic [47:0] stolen [NREC];
        logic [9:0]  link [NREC];
        logic [31:0] visits [NREC];
        logic [47:0] sum_t [NREC];
        logic [47:0] least [NREC];
        logic [47:0] most [NREC];
        logic [47:0] wall_max [NREC];
        logic [9:0]  deep [NREC];
        profile_t    due [$];
        int          errors;
        int          shown;

        function new();
            now = '0;
            cur = NoneExc;
            depth = '0;
            errors = 0;
            shown = 0;
            for (int i = 0; i < NREC; i++) begin
                stamp[i] = '0;
                own[i] = '0;
                stolen[i] = '0;
                link[i] = NoneExc;
                visits[i] = '0;
                sum_t[i] = '0;
                least[i] = '0;
                most[i] = '0;
                wall_max[i] = '0;
                deep[i] = '0;
            end
        endfunction

        function logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
            logic [48:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[48] ? SAT48 : s[47:0];
        endfunction

        function void pop_level();
            logic [8:0]  c;
            logic [47:0] used;
            logic [47:0] steal;
            logic [47:0] wall;
            if (cur >= NREC) begin
                cur = NoneExc;
                return;
            end
            c = cur[8:0];
            used = now - stamp[c];
            steal = stolen[c];
            own[c] = own[c] + used;
            if (visits[c] != VisitMax) visits[c]++;
            sum_t[c] = sat_add(sum_t[c], own[c]);
            stamp[c] = '0;
            if (least[c] == 0 || own[c] < least[c]) least[c] = own[c];
            if (own[c] > most[c]) most[c] = own[c];
            wall = sat_add(own[c], steal);
            if (wall > wall_max[c]) wall_max[c] = wall;
            if (depth > deep[c]) deep[c] = depth;
            cur = (link[c] < NREC) ? link[c] : NoneExc;
            if (depth != 0) depth--;
            if (cur != NoneExc) begin
                stamp[cur[8:0]] = now;
                stolen[cur[8:0]] = stolen[cur[8:0]] + used + steal;
            end
        endfunction

        function void note(logic [2:0] act, logic [8:0] exc, logic [31:0] inc);
            profile_t r;
            r = '0;
            case (act)
                ACT_TICK: now = now + {16'd0, inc};
                ACT_ENTER: begin
                    if (stamp[exc] == 0) begin
                        if (cur != NoneExc)
                            own[cur[8:0]] = own[cur[8:0]] + (now - stamp[cur[8:0]]);
                        link[exc] = cur;
                        cur = {1'b0, exc};
                        stamp[exc] = now;
                        own[exc] = '0;
                        stolen[exc] = '0;
                        if (depth < DepthMax) depth++;
                    end
                end
                ACT_EXIT: if (cur != NoneExc) pop_level();
                ACT_RESUME: begin
                    while (cur != {1'b0, exc} && depth != 0) begin
                        if (cur == NoneExc) depth--;
                        else pop_level();
                    end
                end
                ACT_READ: begin
                    r.rec_valid = 1'b1;
                    r.visits = visits[exc];
                    r.peak_depth = deep[exc];
                    r.total = sum_t[exc];
                    r.min_t = least[exc];
                    r.max_t = most[exc];
                    r.max_wall = wall_max[exc];
                    visits[exc] = '0;
                    deep[exc] = '0;
                    sum_t[exc] = '0;
                    least[exc] = '0;
                    most[exc] = '0;
                    wall_max[exc] = '0;
                end
                ACT_OVF: depth = '0;
                default: ;
            endcase
            r.cur_exc = cur;
            r.depth = depth;
            due.push_back(r);
        endfunction

        function void check(profile_t got);
            profile_t want;
            if (due.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected result %h", got);
                end
                return;
            end
            want = due.pop_front();
            if (got.rec_valid != want.rec_valid || got.visits != want.visits ||
                got.peak_depth != want.peak_depth || got.total != want.total ||
                got.min_t != want.min_t || got.max_t != want.max_t ||
                got.max_wall != want.max_wall || got.cur_exc != want.cur_exc ||
                got.depth != want.depth) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("mismatch: exp rv=%0d vis=%0d md=%0d tot=%0d",
                             want.rec_valid, want.visits, want.peak_depth, want.total);
                    $display("          exp min=%0d max=%0d wall=%0d cur=%0d dep=%0d",
                             want.min_t, want.max_t, want.max_wall, want.cur_exc,
                             want.depth);
                    $display("          got rv=%0d vis=%0d md=%0d tot=%0d",
                             got.rec_valid, got.visits, got.peak_depth, got.total);
                    $display("          got min=%0d max=%0d wall=%0d cur=%0d dep=%0d",
                             got.min_t, got.max_t, got.max_wall, got.cur_exc,
                             got.depth);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_action;
    logic [8:0]  i_exception_number;
    logic [31:0] i_time_increment;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_record_valid;
    logic [31:0] o_visits;
    logic [9:0]  o_peak_depth;
    logic [47:0] o_total_time;
    logic [47:0] o_min_time;
    logic [47:0] o_max_time;
    logic [47:0] o_max_wall_time;
    logic [9:0]  o_current_exception;
    logic [9:0]  o_nesting_depth;

    profile_scoreboard sb;
    int unsigned cycles = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;

    nested_exception_time_profiler dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = ACT_TICK;
        i_exception_number = '0;
        i_time_increment = '0;
        sb = new();
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver stall pattern: switch between free, light and heavy stalling
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 200);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: i_out_stall = 1'b0;
            1: i_out_stall = ($urandom_range(0, 3) == 0);
            default: i_out_stall = ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check({o_record_valid, o_visits, o_peak_depth, o_total_time, o_min_time,
                      o_max_time, o_max_wall_time, o_current_exception, o_nesting_depth});
    end

    task automatic send_req(input logic [2:0] act, input logic [8:0] exc,
                            input logic [31:0] inc);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_action = act;
        i_exception_number = exc;
        i_time_increment = inc;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note(act, exc, inc);
    endtask

    task automatic idle_gap(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    task automatic drain();
        while (sb.due.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random();
        int unsigned sel;
        logic [8:0]  exc;
        logic [31:0] inc;
        sel = $urandom_range(0, 99);
        exc = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0, 1: inc = $urandom;
            2, 3: inc = $urandom_range(0, 65535);
            4: inc = '0;
            default: inc = $urandom_range(1, 50);
        endcase
        if (sel < 30) send_req(ACT_TICK, exc, inc);
        else if (sel < 55) send_req(ACT_ENTER, exc, inc);
        else if (sel < 77) send_req(ACT_EXIT, exc, inc);
        else if (sel < 85) send_req(ACT_RESUME, exc, inc);
        else if (sel < 96) send_req(ACT_READ, exc, inc);
        else if (sel < 98) send_req(ACT_OVF, exc, inc);
        else send_req(3'($urandom_range(6, 7)), exc, inc);
    endtask

    initial begin
        int unsigned burst;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // enter at time zero stays not live, so repeated enters pile up depth
        for (int unsigned k = 0; k < 1030; k++) send_req(ACT_ENTER, 9'd5, '0);
        send_req(ACT_RESUME, 9'd5, '0);
        send_req(ACT_RESUME, 9'd7, '0);
        send_req(ACT_EXIT, 9'd0, '0);
        send_req(ACT_READ, 9'd5, '0);
        send_req(ACT_TICK, 9'd0, 32'hFFFF_FFFF);
        send_req(ACT_ENTER, 9'd0, 32'hFFFF_FFFF);
        send_req(ACT_ENTER, 9'd0, '0);
        send_req(ACT_TICK, 9'd0, 32'd100);
        send_req(ACT_ENTER, 9'd511, '0);
        send_req(ACT_TICK, 9'd0, 32'd7);
        send_req(ACT_ENTER, 9'd3, '0);
        send_req(ACT_TICK, 9'd0, 32'd20);
        send_req(ACT_EXIT, 9'd0, '0);
        send_req(ACT_TICK, 9'd0, 32'd3);
        send_req(ACT_RESUME, 9'd0, '0);
        send_req(ACT_READ, 9'd511, '0);
        send_req(ACT_READ, 9'd511, '0);
        send_req(ACT_OVF, 9'd0, '0);
        send_req(ACT_EXIT, 9'd0, '0);
        send_req(ACT_RESUME, 9'd9, '0);
        send_req(3'd6, 9'd0, '0);
        send_req(3'd7, 9'h1FF, 32'hFFFF_FFFF);
        send_req(ACT_READ, 9'd0, '0);
        send_req(ACT_READ, 9'd3, '0);

        for (int unsigned n = 0; n < 900; n += burst) begin
            burst = $urandom_range(1, 40);
            for (int unsigned k = 0; k < burst; k++) send_random();
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
            if (n > 400 && n < 460) begin
                idle_gap(1);
                drain();
            end
        end
        idle_gap(1);
        drain();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.due.size() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
